>>> rtl/core/tag_frame_parser_smoother_macros.svh
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef TAG_FRAME_PARSER_SMOOTHER_MACROS_SVH
`define TAG_FRAME_PARSER_SMOOTHER_MACROS_SVH

// same-cycle implication
`define TFPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tfps_pkg.sv
package tfps_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] CMD_PLAIN = 8'hF1;
  localparam logic [7:0] CMD_T0    = 8'hA0;
  localparam logic [7:0] CMD_T1    = 8'hA1;
  localparam logic [7:0] CMD_T2    = 8'hA2;

  typedef logic [2:0] pos_t;
  localparam pos_t POS_HDR  = 3'd0;
  localparam pos_t POS_CMD  = 3'd1;
  localparam pos_t POS_TAG  = 3'd2;
  localparam pos_t POS_XLO  = 3'd3;
  localparam pos_t POS_XHI  = 3'd4;
  localparam pos_t POS_YLO  = 3'd5;
  localparam pos_t POS_LAST = 3'd6;

  localparam logic [3:0] WEIGHT_FULL  = 4'd10;
  localparam logic [3:0] WEIGHT_RESET = 4'd3;

  // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every x below 2**22
  localparam logic [19:0] DIV10_RECIP = 20'd838861;
  localparam int          DIV10_SHIFT = 23;

  typedef struct packed {
    logic        valid;
    logic [7:0]  command;
    logic [7:0]  tag;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } frame_t;

  function automatic logic cmd_ok(input logic [7:0] b);
    return (b == CMD_PLAIN) || (b == CMD_T0) || (b == CMD_T1) || (b == CMD_T2);
  endfunction

endpackage

>>> rtl/core/tfps_parser.sv
`include "tag_frame_parser_smoother_macros.svh"

module tfps_parser
  import tfps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_byte
  output frame_t     frame,
  input  logic       frame_ready
);

  logic       in_valid;
  logic [7:0] in_byte;
  pos_t       pos;
  logic [7:0] cmd_q;
  logic [7:0] tag_q;
  logic [7:0] x_lo;
  logic [7:0] x_hi;
  logic [7:0] y_lo;
  logic       at_last;
  logic       consume;

  assign at_last       = in_valid && (pos == POS_LAST);
  // a completing byte waits until the blend stage is empty
  assign consume       = in_valid && (!at_last || frame_ready);
  assign s_axis_tready = !in_valid || consume;

  assign frame.valid   = at_last;
  assign frame.command = cmd_q;
  assign frame.tag     = tag_q;
  assign frame.raw_x   = {x_hi, x_lo};
  assign frame.raw_y   = {in_byte, y_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      pos      <= POS_HDR;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_axis_tdata;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        unique case (pos)
          POS_HDR: begin
            if (in_byte == HDR_BYTE) pos <= POS_CMD;
          end
          POS_CMD: begin
            if (cmd_ok(in_byte)) begin
              cmd_q <= in_byte;
              pos   <= POS_TAG;
            end else begin
              pos <= POS_HDR;
            end
          end
          POS_TAG: begin
            tag_q <= in_byte;
            pos   <= POS_XLO;
          end
          POS_XLO: begin
            x_lo <= in_byte;
            pos  <= POS_XHI;
          end
          POS_XHI: begin
            x_hi <= in_byte;
            pos  <= POS_YLO;
          end
          POS_YLO: begin
            y_lo <= in_byte;
            pos  <= POS_LAST;
          end
          POS_LAST: begin
            pos <= POS_HDR;
          end
          default: begin
            pos <= POS_HDR;
          end
        endcase
      end
    end
  end

  `TFPS_ASSERT_NXT(a_bad_cmd_restarts, consume && pos == POS_CMD && !cmd_ok(in_byte), pos == POS_HDR, "bad command did not restart frame")
  `TFPS_ASSERT_NXT(a_stalled_byte_held, in_valid && !consume, in_valid && $stable(in_byte) && $stable(pos), "stalled byte lost")

endmodule

>>> rtl/core/tfps_blend.sv
`include "tag_frame_parser_smoother_macros.svh"

module tfps_blend
  import tfps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  frame_t      frame,
  output logic        frame_ready,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // command_byte, tag_flag, center_x, center_y
);

  logic [3:0]  weight;
  logic [3:0]  w_eff;
  logic [15:0] smoothed_x;
  logic [15:0] smoothed_y;
  logic        acc_valid;
  logic [7:0]  acc_cmd;
  logic [7:0]  acc_tag;
  logic [19:0] acc_x;
  logic [19:0] acc_y;
  logic [19:0] acc_x_next;
  logic [19:0] acc_y_next;
  logic [39:0] prod_x;
  logic [39:0] prod_y;
  logic [15:0] q_x;
  logic [15:0] q_y;
  logic        out_free;
  logic        move;

  assign w_eff = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;

  // weighted sum, at most 10 * 65535
  assign acc_x_next = 20'(w_eff) * 20'(smoothed_x)
                    + 20'(WEIGHT_FULL - w_eff) * 20'(frame.raw_x);
  assign acc_y_next = 20'(w_eff) * 20'(smoothed_y)
                    + 20'(WEIGHT_FULL - w_eff) * 20'(frame.raw_y);

  // divide by ten through the reciprocal
  assign prod_x = 40'(acc_x) * 40'(DIV10_RECIP);
  assign prod_y = 40'(acc_y) * 40'(DIV10_RECIP);
  assign q_x    = prod_x[DIV10_SHIFT +: 16];
  assign q_y    = prod_y[DIV10_SHIFT +: 16];

  // no reload while draining, so the next sum sees the updated smoothed values
  assign frame_ready = !acc_valid;
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign move        = acc_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight        <= WEIGHT_RESET;
      smoothed_x    <= '0;
      smoothed_y    <= '0;
      acc_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) weight <= cfg_wdata;
      if (frame.valid && frame_ready) begin
        acc_valid <= 1'b1;
        acc_cmd   <= frame.command;
        acc_tag   <= frame.tag;
        acc_x     <= acc_x_next;
        acc_y     <= acc_y_next;
      end else if (move) begin
        acc_valid <= 1'b0;
      end
      if (move) begin
        smoothed_x    <= q_x;
        smoothed_y    <= q_y;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {q_y, q_x, acc_tag, acc_cmd};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `TFPS_ASSERT_NXT(a_acc_drains, move, !acc_valid, "blend stage reloaded while draining")
  `TFPS_ASSERT_NXT(a_out_matches_state, move, m_axis_tvalid && m_axis_tdata[31:16] == smoothed_x && m_axis_tdata[47:32] == smoothed_y, "result differs from smoothed state")
  `TFPS_ASSERT_IMP(a_weight_range, 1'b1, w_eff <= WEIGHT_FULL, "weight not clamped")

endmodule

>>> rtl/core/tag_frame_parser_smoother.sv
// tag frame parser with coordinate smoothing
// s_axis carries one received byte per transaction. Frames are seven bytes:
// header 0xFF, a command (0xF1, 0xA0, 0xA1, 0xA2), a tag byte, then x and y
// as little-endian 16-bit values. Bytes that do not start a frame are
// dropped; a bad command byte restarts the search for a header.
// Each completed frame gives one m_axis transaction with the command, the
// tag and both coordinates after smoothing:
//   new = floor((w*old + (10-w)*raw) / 10), w from cfg_wdata (above 10 acts as 10).
// Throughput: one byte per cycle while s_axis_tready is high; a result can follow at most every seven bytes.
// The result moves from the input register to the weighted-sum register and
// then to the output register, where m_axis_tvalid rises; either move can stall.
// When m_axis stalls, the result holds in the output register and bytes keep
// flowing while the next completed frame waits in the weighted-sum register;
// s_axis_tready drops only when the last byte of a third frame sits in the
// input register, and stays low until the weighted-sum register moves on.
// Reset (rst, synchronous) clears the frame position, the smoothed values
// and all valid flags, and sets the weight to 3. cfg_we writes the weight; the user must
// assert it only while no frame is in flight, which the block itself does not enforce.
module tag_frame_parser_smoother
  import tfps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // old_weight_tenths
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // command_byte, tag_flag, center_x, center_y
);

  frame_t frame;
  logic   frame_ready;

  tfps_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .frame         (frame),
    .frame_ready   (frame_ready)
  );

  tfps_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .frame         (frame),
    .frame_ready   (frame_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/tag_frame_parser_smoother_tb.sv
`timescale 1ns / 100ps

module tag_frame_parser_smoother_tb;
  import tfps_pkg::*;

  typedef struct {
    logic [7:0]  command;
    logic [7:0]  tag;
    logic [15:0] x;
    logic [15:0] y;
  } tag_result_t;

  class tag_frame_tracker;
    logic [3:0]  weight;
    pos_t        pos;
    logic [7:0]  frame [7];
    logic [15:0] smooth_x;
    logic [15:0] smooth_y;
    tag_result_t expected_frames [$];
    int          errors;

    function new();
      weight   = WEIGHT_RESET;
      pos      = POS_HDR;
      smooth_x = '0;
      smooth_y = '0;
      errors   = 0;
    endfunction

    function bit known_command(logic [7:0] b);
      case (b)
        CMD_PLAIN, CMD_T0, CMD_T1, CMD_T2: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [15:0] smooth(logic [15:0] prev, logic [15:0] raw);
      int unsigned wt;
      int unsigned acc;
      // weights above full scale saturate, so the raw value drops out
      wt  = (weight > WEIGHT_FULL) ? int'(WEIGHT_FULL) : int'(weight);
      acc = wt * prev + (int'(WEIGHT_FULL) - wt) * raw;
      return 16'(acc / int'(WEIGHT_FULL));
    endfunction

    function void take_byte(logic [7:0] b);
      tag_result_t r;
      if (pos == POS_HDR && b != HDR_BYTE) return;
      if (pos == POS_CMD && !known_command(b)) begin
        pos = POS_HDR;
        return;
      end
      frame[pos] = b;
      if (pos != POS_LAST) begin
        pos = pos + 3'd1;
        return;
      end
      pos      = POS_HDR;
      smooth_x = smooth(smooth_x, {frame[POS_XHI], frame[POS_XLO]});
      smooth_y = smooth(smooth_y, {frame[POS_LAST], frame[POS_YLO]});
      r.command = frame[POS_CMD];
      r.tag     = frame[POS_TAG];
      r.x       = smooth_x;
      r.y       = smooth_y;
      expected_frames.push_back(r);
    endfunction

    function void check_frame(logic [47:0] data);
      tag_result_t want;
      if (expected_frames.size() == 0) begin
        $error("result %h with no frame pending", data);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (data[7:0] !== want.command) begin
        $error("command_byte: expected %h, got %h", want.command, data[7:0]);
        errors++;
      end
      if (data[15:8] !== want.tag) begin
        $error("tag_flag: expected %h, got %h", want.tag, data[15:8]);
        errors++;
      end
      if (data[31:16] !== want.x) begin
        $error("center_x: expected %0d, got %0d", want.x, data[31:16]);
        errors++;
      end
      if (data[47:32] !== want.y) begin
        $error("center_y: expected %0d, got %0d", want.y, data[47:32]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;      // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // command_byte, tag_flag, center_x, center_y

  tag_frame_tracker tracker;
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [15:0] ready_cyc = '0;
  logic [1:0]  ready_mode = '0;

  tag_frame_parser_smoother dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver backpressure: a random mode is drawn whenever ready_cyc[6:0] is zero
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_cyc     <= '0;
      ready_mode    <= '0;
    end else begin
      ready_cyc <= ready_cyc + 16'd1;
      if (ready_cyc[6:0] == 7'd0) ready_mode <= 2'($urandom_range(0, 3));
      case (ready_mode)
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= ($urandom_range(0, 9) == 0);
        default: m_axis_tready <= (ready_cyc[4:0] < 5'd12);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_frame(m_axis_tdata);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    tracker.take_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] tag,
                            input logic [15:0] x, input logic [15:0] y);
    send_byte(HDR_BYTE);
    send_byte(cmd);
    send_byte(tag);
    send_byte(x[7:0]);
    send_byte(x[15:8]);
    send_byte(y[7:0]);
    send_byte(y[15:8]);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 3))
      0: return CMD_PLAIN;
      1: return CMD_T0;
      2: return CMD_T1;
      default: return CMD_T2;
    endcase
  endfunction

  task automatic send_random(input int count);
    int stop_at;
    int kind;
    int extra;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(pick_command(), 8'($urandom), pick_coord(), pick_coord());
      end else if (kind < 80) begin
        send_byte(8'($urandom));
      end else if (kind < 88) begin
        // header followed by a likely bad command
        send_byte(HDR_BYTE);
        send_byte(8'($urandom));
      end else begin
        // cut-off frame; whatever follows lands in its data bytes
        send_byte(HDR_BYTE);
        send_byte(pick_command());
        extra = $urandom_range(0, 4);
        repeat (extra) send_byte(8'($urandom));
      end
    end
  endtask

  // let the pipeline empty, including bytes that produce nothing
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_weight(input logic [3:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.weight = w;
  endtask

  initial begin
    logic [3:0] weights [8];
    tracker = new();
    weights = '{4'd0, 4'd10, 4'd15, 4'd7, 4'd1, 4'd11, 4'd5, 4'd0};
    weights[7] = 4'($urandom_range(0, 15));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // bad header, bad command (including a repeated header byte), then clean frames
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'h7F);
    send_frame(CMD_PLAIN, 8'h00, 16'h0000, 16'hFFFF);
    send_frame(CMD_T0, 8'hFF, 16'hFFFF, 16'h0000);
    send_frame(CMD_T1, 8'h5A, 16'h8001, 16'h7FFE);
    send_random(45);

    foreach (weights[i]) begin
      drain();
      write_weight(weights[i]);
      send_random(45);
    end

    drain();
    repeat (12) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tfps_pkg.sv
rtl/core/tfps_parser.sv
rtl/core/tfps_blend.sv
rtl/core/tag_frame_parser_smoother.sv
tb/tag_frame_parser_smoother_tb.sv
